// File: rtl/core/sst_pkg.sv
// ----------------------------------------------------------------------------
// sst_pkg
// shared constants for the sorted state table
// ----------------------------------------------------------------------------
package sst_pkg;
  localparam int KEY_DEPTH  = 64;
  localparam int ITEM_DEPTH = 256;
  localparam int KAW = $clog2(KEY_DEPTH);
  localparam int IAW = $clog2(ITEM_DEPTH);
  localparam int KEY_W = 20;
  localparam int HEAD_W = IAW + 1;
  localparam int ENT_W = KEY_W + HEAD_W;
  localparam int PAY_W = 48;
  localparam int ITEM_W = PAY_W + HEAD_W;

  localparam logic [1:0] ST_FOUND    = 2'd0;
  localparam logic [1:0] ST_INSERTED = 2'd1;
  localparam logic [1:0] ST_POOLFULL = 2'd2;
  localparam logic [1:0] ST_KEYFULL  = 2'd3;

  localparam logic [HEAD_W-1:0] HEAD_EMPTY = HEAD_W'(ITEM_DEPTH);
endpackage

// File: rtl/core/sorted_state_table_with_item_lists.sv
// ----------------------------------------------------------------------------
// sorted_state_table_with_item_lists
// binary search over a sorted key ram, insert by shifting, item list push
// ----------------------------------------------------------------------------
// timing: done follows s search steps (s <= log2(KEY_DEPTH)+1, none on an
// empty table); an insert adds a read and a write for each of m shifted
// entries; a full item pool answers in the cycle after accept
// transactions: one at a time; the next
// transaction can be accepted in the cycle its predecessor's result is strobed
// reset: synchronous, clears key and item counts; rams are not cleared;
// results are strobed for one cycle; the receiver cannot stall
module sorted_state_table_with_item_lists (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [7:0]  shader_id,
  input  logic [11:0] atom_texture,
  input  logic [11:0] replace_texture,
  input  logic        use_replace,
  input  logic [15:0] model_handle,
  input  logic [15:0] atom_handle,
  input  logic [15:0] xform_handle,
  output logic        done,
  output logic [1:0]  status,
  output logic [5:0]  key_slot,
  output logic [7:0]  item_slot,
  output logic [8:0]  prior_head
);
  localparam int KAW = sst_pkg::KAW;
  localparam int KCW = KAW + 1;
  localparam int ICW = sst_pkg::IAW + 1;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_SRD   = 3'd1;
  localparam logic [2:0] S_SCMP  = 3'd2;
  localparam logic [2:0] S_CHK   = 3'd3;
  localparam logic [2:0] S_SHRD  = 3'd4;
  localparam logic [2:0] S_SHWR  = 3'd5;
  localparam logic [2:0] S_FIN   = 3'd6;

  logic [2:0] state;
  logic [KCW-1:0] key_count, lo, hi, idx;
  logic [ICW-1:0] item_count;
  logic [sst_pkg::KEY_W-1:0] key;
  logic [sst_pkg::PAY_W-1:0] pay;

  // key and item ram port signals
  logic kwe;
  logic [KAW-1:0] kwaddr, kraddr;
  logic [sst_pkg::ENT_W-1:0] kwdata, krdata;
  logic iwe;
  logic [sst_pkg::ITEM_W-1:0] iwdata;

  sst_ram #(.WIDTH(sst_pkg::ENT_W), .DEPTH(sst_pkg::KEY_DEPTH)) u_key (
    .clk(clk), .we(kwe), .waddr(kwaddr), .wdata(kwdata),
    .raddr(kraddr), .rdata(krdata)
  );

  sst_ram #(.WIDTH(sst_pkg::ITEM_W), .DEPTH(sst_pkg::ITEM_DEPTH)) u_item (
    .clk(clk), .we(iwe), .waddr(item_count[sst_pkg::IAW-1:0]), .wdata(iwdata),
    .raddr(item_count[sst_pkg::IAW-1:0]), .rdata()
  );

  logic [KCW-1:0] mid;
  assign mid = lo + ((hi - lo) >> 1);
  assign busy = (state != S_IDLE);

  logic [sst_pkg::KEY_W-1:0] rkey;
  logic [sst_pkg::HEAD_W-1:0] rhead;
  assign rkey  = krdata[sst_pkg::ENT_W-1:sst_pkg::HEAD_W];
  assign rhead = krdata[sst_pkg::HEAD_W-1:0];

  // in the first FIN the read data holds slot lo; after a shift idx is below key_count
  logic found;
  assign found = (idx == key_count) && (lo < key_count) && (rkey == key);

  // FIN writes both rams on a key hit, or on an insert with no shift left to do
  logic commit;
  assign commit = found || ((key_count < KCW'(sst_pkg::KEY_DEPTH)) && !(idx > lo));

  // ram address and write control
  always_comb begin
    kwe = 1'b0;
    kwaddr = lo[KAW-1:0];
    kwdata = krdata;
    kraddr = mid[KAW-1:0];
    iwe = 1'b0;
    iwdata = {pay, rhead};
    unique case (state)
      S_CHK: kraddr = lo[KAW-1:0];
      S_SHRD: kraddr = idx[KAW-1:0] - KAW'(1);
      S_SHWR: begin
        kwe = 1'b1;
        kwaddr = idx[KAW-1:0];
      end
      S_FIN: begin
        kwe = commit;
        kwaddr = lo[KAW-1:0];
        kwdata = {key, sst_pkg::HEAD_W'(item_count)};
        iwe = commit;
        iwdata = {pay, found ? rhead : sst_pkg::HEAD_EMPTY};
      end
      default: ;
    endcase
  end

  // control sequencer
  always_ff @(posedge clk) begin
    done <= 1'b0;
    if (rst) begin
      state <= S_IDLE;
      key_count <= '0;
      item_count <= '0;
    end else begin
      unique case (state)
        S_IDLE: if (start) begin
          key <= {shader_id, use_replace ? replace_texture : atom_texture};
          pay <= {model_handle, atom_handle, xform_handle};
          lo <= '0;
          hi <= key_count;
          if (item_count >= ICW'(sst_pkg::ITEM_DEPTH)) begin
            done <= 1'b1;
            status <= sst_pkg::ST_POOLFULL;
            key_slot <= '0; item_slot <= '0; prior_head <= '0;
          end else state <= (key_count == '0) ? S_CHK : S_SRD;
        end
        S_SRD: state <= S_SCMP;
        S_SCMP: begin
          if (rkey < key) lo <= mid + KCW'(1);
          else hi <= mid;
          state <= ((rkey < key) ? (mid + KCW'(1) < hi) : (lo < mid)) ? S_SRD : S_CHK;
        end
        S_CHK: state <= S_FIN;
        default: ;
      endcase
      // after the read of slot lo: found, key table full or insert; then the shift
      unique case (state)
        S_FIN: begin
          if (found) begin
            done <= 1'b1;
            status <= sst_pkg::ST_FOUND;
            key_slot <= 6'(lo);
            item_slot <= 8'(item_count);
            prior_head <= 9'(rhead);
            item_count <= item_count + ICW'(1);
            state <= S_IDLE;
          end else if (key_count >= KCW'(sst_pkg::KEY_DEPTH)) begin
            done <= 1'b1;
            status <= sst_pkg::ST_KEYFULL;
            key_slot <= '0; item_slot <= '0; prior_head <= '0;
            state <= S_IDLE;
          end else if (idx > lo) begin
            state <= S_SHRD;
          end else begin
            done <= 1'b1;
            status <= sst_pkg::ST_INSERTED;
            key_slot <= 6'(lo);
            item_slot <= 8'(item_count);
            prior_head <= 9'(sst_pkg::HEAD_EMPTY);
            item_count <= item_count + ICW'(1);
            key_count <= key_count + KCW'(1);
            state <= S_IDLE;
          end
        end
        S_SHRD: state <= S_SHWR;
        S_SHWR: begin
          idx <= idx - KCW'(1);
          state <= (idx - KCW'(1) > lo) ? S_SHRD : S_FIN;
        end
        S_CHK: idx <= key_count;
        default: ;
      endcase
    end
  end
endmodule

// File: rtl/core/sst_ram.sv
// ----------------------------------------------------------------------------
// sst_ram
// generic single-port write, single-port read ram with registered read
// ----------------------------------------------------------------------------
module sst_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  // write and registered read
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule

// File: verif/tb_sorted_state_table_with_item_lists.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_sorted_state_table_with_item_lists
// self-checking bench: predicts status, key slot, item slot and prior list
// head for every accepted draw item and compares each strobed result
// ----------------------------------------------------------------------------
module tb_sorted_state_table_with_item_lists;

  localparam int TOTAL_ITEMS = 1150;
  localparam int IDLE_LIMIT  = 5000;

  typedef struct packed {
    logic [1:0] status;
    logic [5:0] key_slot;
    logic [7:0] item_slot;
    logic [8:0] prior_head;
  } draw_result_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        start = 1'b0;
  logic        busy;
  logic [7:0]  shader_id = '0;
  logic [11:0] atom_texture = '0;
  logic [11:0] replace_texture = '0;
  logic        use_replace = 1'b0;
  logic [15:0] model_handle = '0;
  logic [15:0] atom_handle = '0;
  logic [15:0] xform_handle = '0;
  logic        done;
  logic [1:0]  status;
  logic [5:0]  key_slot;
  logic [7:0]  item_slot;
  logic [8:0]  prior_head;

  // predicted table contents
  logic [sst_pkg::KEY_W-1:0]  key_tbl [sst_pkg::KEY_DEPTH];
  logic [sst_pkg::HEAD_W-1:0] head_tbl [sst_pkg::KEY_DEPTH];
  int unsigned       key_cnt = 0;
  int unsigned       item_cnt = 0;

  draw_result_t pending_results[$];
  int           error_count = 0;
  int           sent_count = 0;
  int           idle_cycles = 0;

  always #2 clk = ~clk;

  sorted_state_table_with_item_lists uut (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .shader_id(shader_id), .atom_texture(atom_texture),
    .replace_texture(replace_texture), .use_replace(use_replace),
    .model_handle(model_handle), .atom_handle(atom_handle),
    .xform_handle(xform_handle), .done(done), .status(status),
    .key_slot(key_slot), .item_slot(item_slot), .prior_head(prior_head)
  );

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("mismatch on %s: got %0d, expected %0d at %0t", what, got, want, $realtime);
    error_count++;
  endtask

  // insert or find the key and push the item onto its list
  function automatic draw_result_t predict_draw(input logic [7:0] sh,
                                                input logic [11:0] tex);
    draw_result_t r;
    logic [sst_pkg::KEY_W-1:0] k;
    int unsigned pos;
    r = '0;
    k = {sh, tex};
    if (item_cnt >= sst_pkg::ITEM_DEPTH) begin
      r.status = sst_pkg::ST_POOLFULL;
      return r;
    end
    pos = 0;
    while (pos < key_cnt && key_tbl[pos] < k) pos++;
    if (pos < key_cnt && key_tbl[pos] == k) begin
      r.status = sst_pkg::ST_FOUND;
    end else begin
      if (key_cnt >= sst_pkg::KEY_DEPTH) begin
        r.status = sst_pkg::ST_KEYFULL;
        return r;
      end
      for (int i = key_cnt; i > pos; i--) begin
        key_tbl[i]  = key_tbl[i-1];
        head_tbl[i] = head_tbl[i-1];
      end
      key_tbl[pos]  = k;
      head_tbl[pos] = sst_pkg::HEAD_EMPTY;
      key_cnt++;
      r.status = sst_pkg::ST_INSERTED;
    end
    r.key_slot   = pos[5:0];
    r.item_slot  = item_cnt[7:0];
    r.prior_head = head_tbl[pos];
    head_tbl[pos] = sst_pkg::HEAD_W'(item_cnt);
    item_cnt++;
    return r;
  endfunction

  // accepted transactions feed the predictor
  always @(posedge clk) begin
    if (!rst && start && !busy) begin
      pending_results.push_back(predict_draw(shader_id,
                                use_replace ? replace_texture : atom_texture));
      sent_count++;
    end
  end

  // compare each strobed result with the oldest prediction
  always @(posedge clk) begin
    draw_result_t want;
    if (!rst && done) begin
      if (pending_results.size() == 0) begin
        report_mismatch("unexpected result", 1, 0);
      end else begin
        want = pending_results.pop_front();
        if (status !== want.status)
          report_mismatch("status", int'(status), int'(want.status));
        if (key_slot !== want.key_slot)
          report_mismatch("key_slot", int'(key_slot), int'(want.key_slot));
        if (item_slot !== want.item_slot)
          report_mismatch("item_slot", int'(item_slot), int'(want.item_slot));
        if (prior_head !== want.prior_head)
          report_mismatch("prior_head", int'(prior_head), int'(want.prior_head));
      end
    end
  end

  // watchdog on cycles without any transaction
  always @(posedge clk) begin
    if (rst || (start && !busy) || done) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  function automatic int pick_gap(input bit no_idle);
    if (no_idle || $urandom_range(0, 9) < 6) return 0;
    if ($urandom_range(0, 9) < 8) return int'($urandom_range(1, 3));
    return int'($urandom_range(8, 60));
  endfunction

  // drive one draw item and hold it until accepted
  task automatic send_draw(input logic [7:0] sh, input logic [11:0] atex,
                           input logic [11:0] rtex, input logic ur,
                           input logic [15:0] mdl, input logic [15:0] atm,
                           input logic [15:0] xf, input int gap);
    if (gap > 0) begin
      start = 1'b0;
      repeat (gap) @(negedge clk);
    end
    while (busy) begin
      start = 1'b0;
      @(negedge clk);
    end
    shader_id = sh; atom_texture = atex; replace_texture = rtex;
    use_replace = ur; model_handle = mdl; atom_handle = atm; xform_handle = xf;
    start = 1'b1;
    @(negedge clk);
    start = 1'b0;
  endtask

  // random item, optionally reusing a key already in the table
  task automatic send_random(input bit reuse, input bit no_idle);
    logic [7:0]  sh;
    logic [11:0] tex, other;
    logic        ur;
    int          i;
    sh = 8'($urandom); tex = 12'($urandom); other = 12'($urandom); ur = 1'($urandom);
    if (reuse && key_cnt > 0) begin
      i = int'($urandom_range(0, key_cnt - 1));
      {sh, tex} = key_tbl[i];
    end
    if (ur) send_draw(sh, other, tex, ur, 16'($urandom), 16'($urandom), 16'($urandom),
                      pick_gap(no_idle));
    else send_draw(sh, tex, other, ur, 16'($urandom), 16'($urandom), 16'($urandom),
                   pick_gap(no_idle));
  endtask

  task automatic wait_drained();
    while (pending_results.size() != 0) @(negedge clk);
  endtask

  // extremes of fields, both texture selects, front/middle/end inserts, hits
  task automatic test_directed();
    send_draw(8'h80, 12'h800, 12'h000, 1'b0, 16'h0000, 16'h0000, 16'h0000, 0);
    send_draw(8'h00, 12'hfff, 12'h000, 1'b1, 16'hffff, 16'hffff, 16'hffff, 0);
    send_draw(8'hff, 12'h000, 12'hfff, 1'b1, 16'h1234, 16'h0000, 16'hffff, 2);
    send_draw(8'h80, 12'h800, 12'h123, 1'b0, 16'h0001, 16'h0002, 16'h0000, 0);
    send_draw(8'h80, 12'h7ff, 12'h801, 1'b1, 16'hffff, 16'h0000, 16'h0001, 0);
    send_draw(8'h7f, 12'hfff, 12'h000, 1'b0, 16'h0000, 16'hffff, 16'h0000, 5);
    send_draw(8'h00, 12'h000, 12'h000, 1'b1, 16'haaaa, 16'h5555, 16'h0000, 0);
    send_draw(8'hff, 12'hfff, 12'h000, 1'b0, 16'h5555, 16'haaaa, 16'hffff, 0);
    send_draw(8'h00, 12'h000, 12'hfff, 1'b0, 16'h0000, 16'h0000, 16'h0000, 0);
    send_draw(8'h80, 12'h000, 12'h801, 1'b1, 16'h0f0f, 16'hf0f0, 16'h00ff, 1);
    send_draw(8'h80, 12'h800, 12'h800, 1'b1, 16'hffff, 16'hffff, 16'hffff, 0);
    send_draw(8'h00, 12'hfff, 12'hfff, 1'b0, 16'h0000, 16'h0000, 16'h0000, 0);
    send_draw(8'h01, 12'h000, 12'hfff, 1'b0, 16'h8000, 16'h0001, 16'h8000, 0);
  endtask

  // fill the key table past full, until the item pool runs out
  task automatic test_key_table_full();
    while (item_cnt < sst_pkg::ITEM_DEPTH) send_random($urandom_range(0, 9) < 4, 1'b0);
  endtask

  // every further item must see a full pool
  task automatic test_item_pool_full();
    bit burst;
    while (sent_count < TOTAL_ITEMS) begin
      burst = ($urandom_range(0, 5) == 0);
      repeat ($urandom_range(5, 30)) send_random(1'($urandom_range(0, 1)), burst);
    end
  endtask

  initial begin
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;
    test_directed();
    wait_drained();
    test_key_table_full();
    wait_drained();
    test_item_pool_full();
    wait_drained();
    repeat (200) @(posedge clk);
    if (error_count == 0) $display("Test completed successfully");
    else $display("Test completed with failures");
    $finish;
  end
endmodule
